### sv/dwmd_pkg.sv
`default_nettype none

package dwmd_pkg;

  // Record layout
  localparam int NGROUPS      = 19;
  localparam int FRAMES_DEF   = 64;
  localparam int HDR_W_SHORT  = 4;
  localparam int HDR_W_LONG   = 5;
  localparam int START_W_BYTE = 8;
  localparam int START_W_WORD = 16;
  localparam int WIDTH_LIMIT  = 16;

  // Group boundaries
  localparam logic [4:0] GRP_FIRST_PAIR = 5'd16;
  localparam logic [4:0] GRP_WORD       = 5'd18;
  localparam logic [4:0] GRP_END        = 5'd19;

  // Frame word positions
  localparam logic [6:0] WORD_PAIR_64 = 7'd64;
  localparam logic [6:0] WORD_PAIR_48 = 7'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DRAIN,
    ST_FLUSH
  } state_t;

  // One decoded result, without the per-byte last flag
  typedef struct packed {
    logic [5:0]  frame_index;
    logic [6:0]  word_position;
    logic [15:0] value;
    logic        record_end;
    logic        width_error;
  } res_t;

  function automatic logic [6:0] word_of_group(input logic [4:0] g);
    logic [6:0] w;
    w = WORD_PAIR_48;
    if (g < GRP_FIRST_PAIR) begin
      unique case (g[3:2])
        2'd0: w = 7'd51;
        2'd1: w = 7'd65;
        2'd2: w = 7'd66;
        2'd3: w = 7'd67;
        default: w = 7'd51;
      endcase
    end else if (g < GRP_WORD) begin
      w = WORD_PAIR_64;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

### sv/dwmd_out_stage.sv
`default_nettype none

module dwmd_out_stage (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  dwmd_pkg::res_t    push_data,
  input  wire               close,
  output logic              stage_open,
  output logic              out_valid,
  input  wire               out_ready,
  output dwmd_pkg::res_t    out_data,
  output logic              out_last
);

  logic           pend_valid_r;
  dwmd_pkg::res_t pend_r;
  logic           out_valid_r;
  dwmd_pkg::res_t out_r;
  logic           last_r;
  logic           slot_free;
  logic           move;

  assign slot_free  = !out_valid_r || out_ready;
  assign stage_open = !pend_valid_r || slot_free;
  // a newer result or the end of the byte releases the held one
  assign move       = pend_valid_r && slot_free && (push || close);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (push) begin
        pend_valid_r <= 1'b1;
      end else if (move) begin
        pend_valid_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      pend_r <= push_data;
    end
    if (move) begin
      out_r  <= pend_r;
      last_r <= close;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

### sv/delta_width_monitor_decoder_core.sv
`default_nettype none

// Channel   Ports                                        Transfer when
// --------  -------------------------------------------  -------------------------
// in        in_data_byte, in_record_start                in_valid && in_ready
// out       out_frame_index, out_word_position,          out_valid && out_ready
//           out_value, out_record_end, out_width_error,
//           out_last
//
// One byte is worked at a time. A byte is taken while idle and goes through the
// bit shifter one bit per cycle, stalling while a value waits for the output
// stage; a flush state then releases the held result. After a value built from
// bits, a drain state checks for zero-width values and emits them one per cycle
// while the output stage is open. A byte ends early once the record is complete.
// Reset (rst_n low, synchronous) empties the output stage and waits for a header.
// A result is held one step back so its last flag is known when it is released.

module delta_width_monitor_decoder_core #(
  parameter int FRAMES = dwmd_pkg::FRAMES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_record_start,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [5:0]  out_frame_index,
  output logic [6:0]  out_word_position,
  output logic [15:0] out_value,
  output logic        out_record_end,
  output logic        out_width_error,
  output logic        out_last
);

  localparam logic [6:0] CNT_QUART = 7'(FRAMES / 4);
  localparam logic [6:0] CNT_HALF  = 7'(FRAMES / 2);
  localparam logic [6:0] CNT_FULL  = 7'(FRAMES);

  dwmd_pkg::state_t state_r, state_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [3:0]  bits_left_r, bits_left_nxt;
  logic [15:0] buf_r, buf_nxt;
  logic [4:0]  held_r, held_nxt;
  logic        hdr_done_r, hdr_done_nxt;
  logic [4:0]  grp_r, grp_nxt;
  logic [5:0]  val_r, val_nxt;
  logic [15:0] prev_r, prev_nxt;
  logic        err_r, err_nxt;
  logic [4:0]  widths_r [dwmd_pkg::NGROUPS];

  logic        wr_en;
  logic        push;
  logic        close;
  logic        stage_open;
  dwmd_pkg::res_t push_data;
  dwmd_pkg::res_t out_data;

  // bit path
  logic [15:0] sh;
  logic [5:0]  held_p;
  logic [4:0]  fw;
  logic [4:0]  cur_w;
  logic        rec_done;

  // value path
  logic [15:0] emit_raw;
  logic [15:0] emit_v;
  logic [6:0]  emit_cnt;
  logic        emit_lastv;
  logic [5:0]  emit_frame;

  assign cur_w    = (grp_r < dwmd_pkg::GRP_END) ? widths_r[grp_r] : 5'd0;
  assign rec_done = hdr_done_r && (grp_r >= dwmd_pkg::GRP_END);
  assign sh       = {buf_r[14:0], byte_r[7]};
  assign held_p   = {1'b0, held_r} + 6'd1;

  // width of the field being collected
  always_comb begin
    if (!hdr_done_r) begin
      fw = (grp_r < dwmd_pkg::GRP_WORD) ? 5'(dwmd_pkg::HDR_W_SHORT)
                                        : 5'(dwmd_pkg::HDR_W_LONG);
    end else if (val_r == 6'd0) begin
      fw = (grp_r == dwmd_pkg::GRP_WORD) ? 5'(dwmd_pkg::START_W_WORD)
                                         : 5'(dwmd_pkg::START_W_BYTE);
    end else begin
      fw = cur_w;
    end
  end

  // accumulate the value and place it in the frame
  always_comb begin
    emit_raw = (state_r == dwmd_pkg::ST_DRAIN) ? 16'd0 : sh;
    emit_v   = (val_r == 6'd0) ? emit_raw : prev_r + emit_raw;
    if (grp_r != dwmd_pkg::GRP_WORD) begin
      emit_v[15:8] = 8'd0;
    end
    if (grp_r < dwmd_pkg::GRP_FIRST_PAIR) begin
      emit_cnt   = CNT_QUART;
      emit_frame = {val_r[3:0], grp_r[1:0]};
    end else if (grp_r < dwmd_pkg::GRP_WORD) begin
      emit_cnt   = CNT_HALF;
      emit_frame = {val_r[4:0], grp_r[0]};
    end else begin
      emit_cnt   = CNT_FULL;
      emit_frame = val_r;
    end
    emit_lastv = ({1'b0, val_r} + 7'd1) >= emit_cnt;
    push_data.frame_index   = emit_frame;
    push_data.word_position = dwmd_pkg::word_of_group(grp_r);
    push_data.value         = emit_v;
    push_data.record_end    = (grp_r == dwmd_pkg::GRP_WORD) && emit_lastv;
    push_data.width_error   = err_r;
  end

  always_comb begin
    state_nxt     = state_r;
    byte_nxt      = byte_r;
    bits_left_nxt = bits_left_r;
    buf_nxt       = buf_r;
    held_nxt      = held_r;
    hdr_done_nxt  = hdr_done_r;
    grp_nxt       = grp_r;
    val_nxt       = val_r;
    prev_nxt      = prev_r;
    err_nxt       = err_r;
    wr_en         = 1'b0;
    push          = 1'b0;
    close         = 1'b0;
    in_ready      = (state_r == dwmd_pkg::ST_IDLE);

    unique case (state_r)
      dwmd_pkg::ST_IDLE: begin
        if (in_valid) begin
          byte_nxt      = in_data_byte;
          bits_left_nxt = 4'd8;
          state_nxt     = dwmd_pkg::ST_SHIFT;
          // start a fresh record before this byte
          if (in_record_start) begin
            buf_nxt      = 16'd0;
            held_nxt     = 5'd0;
            hdr_done_nxt = 1'b0;
            grp_nxt      = 5'd0;
            val_nxt      = 6'd0;
            prev_nxt     = 16'd0;
          end
        end
      end

      dwmd_pkg::ST_SHIFT: begin
        if (bits_left_r == 4'd0 || rec_done) begin
          // leave once the byte is used up, or drop the rest of it once the record is complete
          state_nxt = dwmd_pkg::ST_FLUSH;
        end else if (held_p < {1'b0, fw}) begin
          byte_nxt      = {byte_r[6:0], 1'b0};
          bits_left_nxt = bits_left_r - 4'd1;
          buf_nxt       = sh;
          held_nxt      = held_p[4:0];
        end else if (!hdr_done_r) begin
          byte_nxt      = {byte_r[6:0], 1'b0};
          bits_left_nxt = bits_left_r - 4'd1;
          buf_nxt       = 16'd0;
          held_nxt      = 5'd0;
          wr_en         = 1'b1;
          if (grp_r == dwmd_pkg::GRP_WORD) begin
            err_nxt      = sh[4:0] > 5'(dwmd_pkg::WIDTH_LIMIT);
            hdr_done_nxt = 1'b1;
            grp_nxt      = 5'd0;
            val_nxt      = 6'd0;
          end else begin
            grp_nxt = grp_r + 5'd1;
          end
        end else if (stage_open) begin
          byte_nxt      = {byte_r[6:0], 1'b0};
          bits_left_nxt = bits_left_r - 4'd1;
          buf_nxt       = 16'd0;
          held_nxt      = 5'd0;
          push          = 1'b1;
          prev_nxt      = emit_v;
          if (emit_lastv) begin
            val_nxt = 6'd0;
            grp_nxt = grp_r + 5'd1;
          end else begin
            val_nxt = val_r + 6'd1;
          end
          state_nxt = dwmd_pkg::ST_DRAIN;
        end
      end

      dwmd_pkg::ST_DRAIN: begin
        // zero-width deltas consume no bits: emit them one per cycle while the output stage is open
        if (grp_r < dwmd_pkg::GRP_END && val_r != 6'd0 && cur_w == 5'd0) begin
          if (stage_open) begin
            push     = 1'b1;
            prev_nxt = emit_v;
            if (emit_lastv) begin
              val_nxt = 6'd0;
              grp_nxt = grp_r + 5'd1;
            end else begin
              val_nxt = val_r + 6'd1;
            end
          end
        end else begin
          state_nxt = dwmd_pkg::ST_SHIFT;
        end
      end

      dwmd_pkg::ST_FLUSH: begin
        // release the held result with its last flag
        if (stage_open) begin
          close     = 1'b1;
          state_nxt = dwmd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = dwmd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dwmd_pkg::ST_IDLE;
      bits_left_r <= 4'd0;
      buf_r       <= 16'd0;
      held_r      <= 5'd0;
      hdr_done_r  <= 1'b0;
      grp_r       <= 5'd0;
      val_r       <= 6'd0;
      prev_r      <= 16'd0;
      err_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bits_left_r <= bits_left_nxt;
      buf_r       <= buf_nxt;
      held_r      <= held_nxt;
      hdr_done_r  <= hdr_done_nxt;
      grp_r       <= grp_nxt;
      val_r       <= val_nxt;
      prev_r      <= prev_nxt;
      err_r       <= err_nxt;
    end
  end

  // byte shifter and width table carry no reset
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    if (wr_en) begin
      widths_r[grp_r] <= sh[4:0];
    end
  end

  dwmd_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .close      (close),
    .stage_open (stage_open),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .out_last   (out_last)
  );

  assign out_frame_index   = out_data.frame_index;
  assign out_word_position = out_data.word_position;
  assign out_value         = out_data.value;
  assign out_record_end    = out_data.record_end;
  assign out_width_error   = out_data.width_error;

endmodule

`default_nettype wire

### sim/delta_width_monitor_decoder_check.sv
`timescale 1ns / 1ps

// Watch both channels, decode each accepted byte and check every result.
module delta_width_monitor_decoder_check #(
  parameter int FRAMES = dwmd_pkg::FRAMES_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  input  wire        in_ready,
  input  wire [7:0]  in_data_byte,
  input  wire        in_record_start,
  input  wire        out_valid,
  input  wire        out_ready,
  input  wire [5:0]  out_frame_index,
  input  wire [6:0]  out_word_position,
  input  wire [15:0] out_value,
  input  wire        out_record_end,
  input  wire        out_width_error,
  input  wire        out_last,
  output int         mismatch_count,
  output int         values_due
);

  typedef struct packed {
    logic [5:0]  frame;
    logic [6:0]  word;
    logic [15:0] value;
    logic        rec_end;
    logic        wide;
    logic        byte_last;
  } decoded_t;

  // words fed by the four blocks of 8-bit groups, lowest block first
  localparam logic [27:0] BLOCK_WORDS = {7'd67, 7'd66, 7'd65, 7'd51};

  logic [23:0] shift_reg;
  int          shift_cnt;
  logic [4:0]  widths [0:dwmd_pkg::NGROUPS-1];
  logic        hdr_done;
  logic [4:0]  grp;
  int          idx;
  logic [15:0] last_val;

  decoded_t    byte_batch [$];
  decoded_t    values_owed [$];
  int          errs = 0;
  int          results_seen = 0;

  function automatic int values_in_group(input logic [4:0] g);
    if (g < dwmd_pkg::GRP_FIRST_PAIR) return FRAMES / 4;
    if (g < dwmd_pkg::GRP_WORD) return FRAMES / 2;
    return FRAMES;
  endfunction

  function automatic int next_field_width();
    if (!hdr_done)
      return (grp < dwmd_pkg::GRP_WORD) ? dwmd_pkg::HDR_W_SHORT : dwmd_pkg::HDR_W_LONG;
    if (idx == 0)
      return (grp == dwmd_pkg::GRP_WORD) ? dwmd_pkg::START_W_WORD : dwmd_pkg::START_W_BYTE;
    return int'(widths[grp]);
  endfunction

  task automatic clear_record();
    shift_reg = '0;
    shift_cnt = 0;
    for (int g = 0; g < dwmd_pkg::NGROUPS; g++) widths[g] = '0;
    hdr_done = 1'b0;
    grp = '0;
    idx = 0;
    last_val = '0;
  endtask

  task automatic emit_value(input logic [15:0] raw);
    decoded_t   d;
    logic [15:0] mask;
    int         cnt;
    int         f;
    cnt = values_in_group(grp);
    mask = (grp == dwmd_pkg::GRP_WORD) ? 16'hFFFF : 16'h00FF;
    d.value = (idx == 0) ? (raw & mask) : ((last_val + raw) & mask);
    last_val = d.value;
    if (grp < dwmd_pkg::GRP_FIRST_PAIR) begin
      d.word = BLOCK_WORDS[grp[3:2]*7 +: 7];
      f = 4 * idx + grp[1:0];
    end else if (grp < dwmd_pkg::GRP_WORD) begin
      d.word = dwmd_pkg::WORD_PAIR_64;
      f = 2 * idx + (grp - dwmd_pkg::GRP_FIRST_PAIR);
    end else begin
      d.word = dwmd_pkg::WORD_PAIR_48;
      f = idx;
    end
    d.frame = f[5:0];
    d.rec_end = (grp == dwmd_pkg::GRP_WORD) && (idx + 1 >= cnt);
    d.wide = widths[dwmd_pkg::NGROUPS-1] > dwmd_pkg::WIDTH_LIMIT;
    d.byte_last = 1'b0;
    if (byte_batch.size() < 64) byte_batch.push_back(d);
    idx++;
    if (idx >= cnt) begin
      idx = 0;
      grp = grp + 5'd1;
    end
  endtask

  task automatic decode_byte(input logic [7:0] data, input logic start);
    logic [23:0] raw;
    byte_batch.delete();
    if (start) clear_record();
    for (int i = 7; i >= 0; i--) begin
      // drop padding once the record is complete
      if (hdr_done && grp >= dwmd_pkg::GRP_END) break;
      shift_reg = {shift_reg[22:0], data[i]};
      shift_cnt++;
      if (shift_cnt >= next_field_width()) begin
        raw = shift_reg;
        shift_reg = '0;
        shift_cnt = 0;
        if (!hdr_done) begin
          widths[grp] = raw[4:0];
          grp = grp + 5'd1;
          if (grp >= dwmd_pkg::GRP_END) begin
            hdr_done = 1'b1;
            grp = '0;
            idx = 0;
          end
        end else begin
          emit_value(raw[15:0]);
          // zero-width deltas take no bits: release them right away
          while (grp < dwmd_pkg::GRP_END && idx > 0 && widths[grp] == 5'd0)
            emit_value(16'd0);
        end
      end
    end
    if (byte_batch.size() > 0) byte_batch[byte_batch.size()-1].byte_last = 1'b1;
    foreach (byte_batch[k]) values_owed.push_back(byte_batch[k]);
  endtask

  task automatic check_result();
    decoded_t got;
    decoded_t want;
    got = {out_frame_index, out_word_position, out_value, out_record_end,
           out_width_error, out_last};
    results_seen++;
    if (values_owed.size() == 0) begin
      errs++;
      if (errs <= 10)
        $display("result %0d with nothing due: frame %0d word %0d value %h end %b wide %b last %b",
                 results_seen, got.frame, got.word, got.value, got.rec_end, got.wide,
                 got.byte_last);
    end else begin
      want = values_owed.pop_front();
      if (got !== want) begin
        errs++;
        if (errs <= 10) begin
          $display("result %0d mismatch", results_seen);
          $display("  expected frame %0d word %0d value %h end %b wide %b last %b",
                   want.frame, want.word, want.value, want.rec_end, want.wide, want.byte_last);
          $display("  actual   frame %0d word %0d value %h end %b wide %b last %b",
                   got.frame, got.word, got.value, got.rec_end, got.wide, got.byte_last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_record();
      values_owed.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) decode_byte(in_data_byte, in_record_start);
    end
    values_due <= values_owed.size();
    mismatch_count <= errs;
  end

endmodule

### sim/delta_width_monitor_decoder_core_test.sv
`timescale 1ns / 1ps

module delta_width_monitor_decoder_core_test;

  localparam int FRAMES = dwmd_pkg::FRAMES_DEF;
  localparam int NGROUPS = dwmd_pkg::NGROUPS;
  localparam int ITEMS = 150;
  // header bits: 18 short widths plus the long one for the 16-bit group
  localparam int HDR_BITS = 18 * dwmd_pkg::HDR_W_SHORT + dwmd_pkg::HDR_W_LONG;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_record_start = 1'b0;
  logic        out_ready = 1'b0;
  wire         in_ready;
  wire         out_valid;
  wire  [5:0]  out_frame_index;
  wire  [6:0]  out_word_position;
  wire  [15:0] out_value;
  wire         out_record_end;
  wire         out_width_error;
  wire         out_last;

  int          bad_count;
  int          left_count;

  // bit stream of the record being built, MSB first
  bit          rec_bits [$];
  int          bit_cap;
  logic [4:0]  plan_w [0:NGROUPS-1];
  int          sent_count = 0;
  int          calm_left = 0;

  delta_width_monitor_decoder_core #(.FRAMES(FRAMES)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_record_start   (in_record_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_index   (out_frame_index),
    .out_word_position (out_word_position),
    .out_value         (out_value),
    .out_record_end    (out_record_end),
    .out_width_error   (out_width_error),
    .out_last          (out_last)
  );

  delta_width_monitor_decoder_check #(.FRAMES(FRAMES)) u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_record_start   (in_record_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_index   (out_frame_index),
    .out_word_position (out_word_position),
    .out_value         (out_value),
    .out_record_end    (out_record_end),
    .out_width_error   (out_width_error),
    .out_last          (out_last),
    .mismatch_count    (bad_count),
    .values_due        (left_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stall the result side: runs of ready broken by short holds, now and
  // then a long hold or a long run with no stall at all.
  initial begin : sink_pacing
    int run;
    int hold;
    @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      out_ready <= 1'b0;
      repeat (hold) @(posedge clk);
    end
  end

  // Offer one byte and hold it until the transfer. Any idle gap comes first,
  // so valid is never dropped and raised in the same step.
  task automatic send_byte(input logic [7:0] d, input logic s);
    int gap;
    int pick;
    gap = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3) calm_left = $urandom_range(20, 60);
      else if (pick < 50) gap = 0;
      else if (pick < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_record_start <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold off the sender until every decoded value due has come out.
  task automatic drain_wait();
    in_valid <= 1'b0;
    @(posedge clk);
    while (left_count != 0) @(posedge clk);
  endtask

  // Mostly random, sometimes all zeros or all ones, over nb bits.
  function automatic logic [31:0] pick_value(input int nb);
    logic [31:0] mask;
    int sel;
    mask = (32'd1 << nb) - 32'd1;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 32'd0;
    if (sel == 1) return mask;
    return $urandom & mask;
  endfunction

  task automatic put_field(input logic [31:0] v, input int nb);
    for (int i = nb - 1; i >= 0; i--)
      if (rec_bits.size() < bit_cap) rec_bits.push_back(v[i]);
  endtask

  function automatic int group_size(input int g);
    if (g < dwmd_pkg::GRP_FIRST_PAIR) return FRAMES / 4;
    if (g < dwmd_pkg::GRP_WORD) return FRAMES / 2;
    return FRAMES;
  endfunction

  // Lay out header and all groups from plan_w, cut off at bit_cap.
  task automatic build_record();
    int sw;
    rec_bits.delete();
    for (int g = 0; g < NGROUPS - 1; g++) put_field(32'(plan_w[g]), dwmd_pkg::HDR_W_SHORT);
    put_field(32'(plan_w[NGROUPS-1]), dwmd_pkg::HDR_W_LONG);
    for (int g = 0; g < NGROUPS; g++) begin
      sw = (g == dwmd_pkg::GRP_WORD) ? dwmd_pkg::START_W_WORD : dwmd_pkg::START_W_BYTE;
      put_field(pick_value(sw), sw);
      for (int j = 1; j < group_size(g); j++)
        put_field(pick_value(int'(plan_w[g])), int'(plan_w[g]));
    end
  endtask

  // Pack the stream into bytes; fill the tail of the last byte at random.
  // Stop early once the run has sent its share of bytes.
  task automatic send_record(input logic mark_start);
    logic [7:0] d;
    int nbytes;
    int pos;
    nbytes = (rec_bits.size() + 7) / 8;
    for (int k = 0; k < nbytes && sent_count < ITEMS; k++) begin
      for (int b = 7; b >= 0; b--) begin
        pos = k * 8 + 7 - b;
        d[b] = (pos < rec_bits.size()) ? rec_bits[pos] : 1'($urandom_range(0, 1));
      end
      send_byte(d, mark_start && k == 0);
      sent_count++;
    end
  endtask

  // Widths for a record: mostly zero-width groups to keep records short.
  // With wide set, the 16-bit group gets a width past the limit.
  task automatic plan_widths(input bit wide);
    int pick;
    for (int g = 0; g < NGROUPS - 1; g++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) plan_w[g] = 5'd0;
      else if (pick < 95) plan_w[g] = 5'($urandom_range(1, 3));
      else plan_w[g] = 5'($urandom_range(4, 15));
    end
    pick = $urandom_range(0, 99);
    if (wide) plan_w[NGROUPS-1] = 5'($urandom_range(dwmd_pkg::WIDTH_LIMIT + 1, 31));
    else if (pick < 70) plan_w[NGROUPS-1] = 5'd0;
    else if (pick < 95) plan_w[NGROUPS-1] = 5'($urandom_range(1, 2));
    else plan_w[NGROUPS-1] = 5'(dwmd_pkg::WIDTH_LIMIT);
  endtask

  // Bits up to and including k deltas of the 16-bit group.
  function automatic int bits_to_word_delta(input int k);
    int n;
    n = HDR_BITS;
    for (int g = 0; g < NGROUPS - 1; g++)
      n += dwmd_pkg::START_W_BYTE + (group_size(g) - 1) * int'(plan_w[g]);
    return n + dwmd_pkg::START_W_WORD + k * int'(plan_w[NGROUPS-1]);
  endfunction

  initial begin : stimulus
    int pick;
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // First record right out of reset, no record_start: the decoder is
    // already waiting for a header. All widths zero, so every group after
    // its start value bursts out at once. Then junk that must be dropped.
    for (int g = 0; g < NGROUPS; g++) plan_w[g] = 5'd0;
    bit_cap = 1 << 30;
    build_record();
    send_record(1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    sent_count += 2;

    // Widest delta on the 16-bit group: flags every value of the record.
    // Cut it off after a few deltas; the next record_start restarts.
    plan_w[NGROUPS-1] = 5'd31;
    bit_cap = bits_to_word_delta(3);
    build_record();
    send_record(1'b1);

    drain_wait();

    while (sent_count < ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // full record, then maybe some trailing junk
        plan_widths(1'b0);
        bit_cap = 1 << 30;
        build_record();
        send_record(1'b1);
        if ($urandom_range(0, 9) < 3) begin
          n = $urandom_range(1, 3);
          repeat (n) begin
            send_byte(8'($urandom), 1'b0);
            sent_count++;
          end
        end
      end else if (pick < 85) begin
        // over-limit width, truncated a few deltas into the last group
        plan_widths(1'b1);
        bit_cap = bits_to_word_delta($urandom_range(1, 6));
        build_record();
        send_record(1'b1);
      end else begin
        // random header and a broken start of a record
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
          send_byte(8'($urandom), k == 0);
          sent_count++;
        end
      end
      if ($urandom_range(0, 9) == 0) drain_wait();
    end

    drain_wait();
    repeat (200) @(posedge clk);
    if (bad_count == 0 && left_count == 0) begin
      $display("[delta_width_monitor_decoder_core] OK");
    end else begin
      $display("[delta_width_monitor_decoder_core] ERROR");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin : watchdog
    #30000000;
    $display("[delta_width_monitor_decoder_core] ERROR");
    $finish;
  end

endmodule
